// ===== rtl/dqomf_pkg.sv =====
// Shared types and constants for the decode queue with ordered merge and tail flush.
// Used by the channel interfaces, the controller, the datapath and the top level.
package dqomf_pkg;

	localparam int DEPTH     = 64;
	localparam int GROUP_MAX = 8;
	localparam int PTR_W     = $clog2(DEPTH);
	localparam int OCC_W     = $clog2(DEPTH + 1);

	localparam logic [1:0] REQ_OFFER   = 2'd0;
	localparam logic [1:0] REQ_DEQUEUE = 2'd1;
	localparam logic [1:0] REQ_PEEK    = 2'd2;
	localparam logic [1:0] REQ_RECOVER = 2'd3;

	localparam logic [1:0] SRC_NONE = 2'd0;
	localparam logic [1:0] SRC_DEC  = 2'd1;
	localparam logic [1:0] SRC_UOPC = 2'd2;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [3:0]  dec_count;
		logic [31:0] dec_first_num;
		logic [3:0]  uopc_count;
		logic [31:0] uopc_first_num;
		logic [31:0] recovery_num;
	} req_t;

	typedef struct packed {
		logic [1:0]  taken_source;
		logic [3:0]  taken_count;
		logic        head_valid;
		logic [31:0] head_num;
		logic [6:0]  flushed_count;
		logic [6:0]  fill_level;
		logic        status;
	} rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic offer_eval;
		logic enq_step;
		logic head_read;
		logic head_take;
		logic rcv_read;
		logic rcv_pop;
		logic rcv_finish;
		logic publish;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [1:0]       req_kind;
		logic             offer_ok;
		logic             empty;
		logic             enq_last;
		logic             rcv_stop;
		logic             out_free;
		logic [OCC_W-1:0] fill;
	} sts_t;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	function automatic logic [PTR_W-1:0] ptr_prev(input logic [PTR_W-1:0] p);
		return (p == '0) ? PTR_W'(DEPTH - 1) : p - PTR_W'(1);
	endfunction

endpackage

// ===== rtl/dqomf_if.sv =====
// Valid/ready channel interfaces for requests and responses of the decode queue.
// Depends on dqomf_pkg for the payload types.
interface dqomf_req_if;
	import dqomf_pkg::*;
	logic valid;
	logic ready;
	req_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface dqomf_rsp_if;
	import dqomf_pkg::*;
	logic valid;
	logic ready;
	rsp_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/dqomf_ctrl.sv =====
// Controller state machine of the decode queue: sequences offers, head reads and
// tail flushes one transaction at a time. Depends on dqomf_pkg.
module dqomf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  dqomf_pkg::sts_t   sts,
	output dqomf_pkg::cmd_t   cmd
);
	import dqomf_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE      = 7'b0000001,
		ST_DISPATCH  = 7'b0000010,
		ST_ENQ       = 7'b0000100,
		ST_HEAD_WAIT = 7'b0001000,
		ST_RCV       = 7'b0010000,
		ST_RCV_CHK   = 7'b0100000,
		ST_FIN       = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign req_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				case (sts.req_kind)
					REQ_OFFER: begin
						cmd.offer_eval = 1'b1;
						state_d        = sts.offer_ok ? ST_ENQ : ST_FIN;
					end
					REQ_DEQUEUE, REQ_PEEK: begin
						if (sts.empty) begin
							state_d = ST_FIN;
						end else begin
							cmd.head_read = 1'b1;
							state_d       = ST_HEAD_WAIT;
						end
					end
					default: begin
						state_d = ST_RCV;
					end
				endcase
			end
			ST_ENQ: begin
				cmd.enq_step = 1'b1;
				if (sts.enq_last) begin
					state_d = ST_FIN;
				end
			end
			ST_HEAD_WAIT: begin
				cmd.head_take = 1'b1;
				state_d       = ST_FIN;
			end
			ST_RCV: begin
				if (sts.empty) begin
					cmd.rcv_finish = 1'b1;
					state_d        = ST_FIN;
				end else begin
					cmd.rcv_read = 1'b1;
					state_d      = ST_RCV_CHK;
				end
			end
			ST_RCV_CHK: begin
				if (sts.rcv_stop) begin
					cmd.rcv_finish = 1'b1;
					state_d        = ST_FIN;
				end else begin
					cmd.rcv_pop = 1'b1;
					state_d     = ST_RCV;
				end
			end
			ST_FIN: begin
				if (sts.out_free) begin
					cmd.publish = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/dqomf_dp.sv =====
// Datapath of the decode queue: entry memory, ring pointers, expected op number,
// group selection, working results and the response register. Depends on dqomf_pkg.
module dqomf_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_wdata,
	input  dqomf_pkg::req_t   req_data,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output dqomf_pkg::rsp_t   rsp_data,
	input  dqomf_pkg::cmd_t   cmd,
	output dqomf_pkg::sts_t   sts
);
	import dqomf_pkg::*;

	logic [31:0]      mem [DEPTH];
	logic [31:0]      rdata_q;

	logic             uopc_en_q;
	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic [OCC_W-1:0] occ_q;
	logic [31:0]      exp_q;
	req_t             req_q;
	logic [3:0]       rem_q;

	logic [1:0]       res_src_q;
	logic [3:0]       res_cnt_q;
	logic             res_hv_q;
	logic [31:0]      res_hnum_q;
	logic [6:0]       res_flushed_q;
	logic             res_st_q;

	logic             rsp_valid_q;
	rsp_t             rsp_q;

	logic [1:0]       sel;
	logic [3:0]       scnt;
	logic             seq_err;
	logic [OCC_W-1:0] free;
	logic             ok;
	logic [PTR_W-1:0] rd_addr;

	// Pick the group whose first op number is the one expected next.
	always_comb begin
		sel     = SRC_NONE;
		seq_err = 1'b0;
		if (uopc_en_q) begin
			if (req_q.dec_count != '0 && req_q.dec_first_num == exp_q) begin
				sel = SRC_DEC;
			end else if (req_q.uopc_count != '0 && req_q.uopc_first_num == exp_q) begin
				sel = SRC_UOPC;
			end
		end else if (req_q.dec_count != '0) begin
			if (req_q.dec_first_num == exp_q) begin
				sel = SRC_DEC;
			end else begin
				seq_err = 1'b1;
			end
		end
		scnt = (sel == SRC_UOPC) ? req_q.uopc_count : req_q.dec_count;
		free = OCC_W'(DEPTH) - occ_q;
		ok   = (sel != SRC_NONE) && (32'(scnt) <= 32'(GROUP_MAX))
			&& (32'(scnt) <= 32'(free));
	end

	assign rd_addr = cmd.head_read ? head_q : ptr_prev(tail_q);

	always_ff @(posedge clk) begin
		if (cmd.enq_step) begin
			mem[tail_q] <= exp_q;
		end
		if (cmd.head_read || cmd.rcv_read) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			uopc_en_q <= 1'b0;
			head_q    <= '0;
			tail_q    <= '0;
			occ_q     <= '0;
			exp_q     <= 32'd1;
		end else begin
			if (cfg_we) begin
				uopc_en_q <= cfg_wdata;
			end
			if (cmd.enq_step) begin
				tail_q <= ptr_next(tail_q);
				occ_q  <= occ_q + OCC_W'(1);
				exp_q  <= exp_q + 32'd1;
			end
			if (cmd.head_take && req_q.req_type == REQ_DEQUEUE) begin
				head_q <= ptr_next(head_q);
				occ_q  <= occ_q - OCC_W'(1);
			end
			if (cmd.rcv_pop) begin
				tail_q <= ptr_prev(tail_q);
				occ_q  <= occ_q - OCC_W'(1);
			end
			if (cmd.rcv_finish && exp_q > req_q.recovery_num) begin
				exp_q <= req_q.recovery_num + 32'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q         <= req_data;
			res_src_q     <= SRC_NONE;
			res_cnt_q     <= '0;
			res_hv_q      <= 1'b0;
			res_hnum_q    <= '0;
			res_flushed_q <= '0;
			res_st_q      <= 1'b0;
		end
		if (cmd.offer_eval) begin
			res_src_q <= ok ? sel : SRC_NONE;
			res_cnt_q <= ok ? scnt : 4'd0;
			res_st_q  <= seq_err;
			rem_q     <= scnt;
		end
		if (cmd.enq_step) begin
			rem_q <= rem_q - 4'd1;
		end
		if (cmd.head_take) begin
			res_hv_q   <= 1'b1;
			res_hnum_q <= rdata_q;
		end
		if (cmd.rcv_pop) begin
			res_flushed_q <= res_flushed_q + 7'd1;
		end
	end

	// Response register: a finished result waits here until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.publish) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			rsp_q.taken_source  <= res_src_q;
			rsp_q.taken_count   <= res_cnt_q;
			rsp_q.head_valid    <= res_hv_q;
			rsp_q.head_num      <= res_hnum_q;
			rsp_q.flushed_count <= res_flushed_q;
			rsp_q.fill_level    <= 7'(occ_q);
			rsp_q.status        <= res_st_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	assign sts.req_kind = req_q.req_type;
	assign sts.offer_ok = ok;
	assign sts.empty    = (occ_q == '0);
	assign sts.enq_last = (rem_q == 4'd1);
	assign sts.rcv_stop = (rdata_q <= req_q.recovery_num);
	assign sts.out_free = !rsp_valid_q || rsp_ready;
	assign sts.fill     = occ_q;

endmodule

// ===== rtl/decode_queue_ordered_merge_flush_top.sv =====
// Decode queue top level, one transaction at a time. An offer writes memory once for each
// op taken and a refused offer writes nothing; a dequeue or peek waits on a registered
// memory read unless the queue is empty; a recover pops ops from the tail until it reaches
// a survivor or empties the queue; a stalled sink holds the response. The next request is
// taken in the cycle after the response is registered. Asynchronous active-low reset
// clears pointers, fill level and control; the expected op number resets to 1.
module decode_queue_ordered_merge_flush_top (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_we,
	input logic        cfg_wdata,
	dqomf_req_if.sink  req,
	dqomf_rsp_if.source rsp
);
	import dqomf_pkg::*;

	cmd_t cmd;
	sts_t sts;

	dqomf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	dqomf_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req_data  (req.data),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.rsp_data  (rsp.data),
		.cmd       (cmd),
		.sts       (sts)
	);

`ifndef SYNTH
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request accepted while another is in flight");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.enq_step |-> sts.fill < OCC_W'(DEPTH))
		else $error("enqueue into a full queue");

	a_taken_source: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.taken_count != 4'd0 |->
			rsp.data.taken_source != SRC_NONE && rsp.data.fill_level != 7'd0)
		else $error("ops taken without a source or occupancy");

	a_head_only: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.head_valid |->
			rsp.data.taken_count == 4'd0 && rsp.data.flushed_count == 7'd0)
		else $error("head response carries offer or flush results");
`endif

endmodule

// ===== tb/sv/decode_queue_checker.sv =====
// Checker for the decode queue: watches both channels and the register port,
// keeps its own copy of the queue, and compares every response with its prediction.
// Depends on dqomf_pkg and the channel interfaces in dqomf_if.sv.
module decode_queue_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	dqomf_req_if        req_mon,
	dqomf_rsp_if        rsp_mon,
	output int          fail_count,
	output int          waiting,
	output logic [31:0] model_next_num,
	output logic [6:0]  model_fill
);
	timeunit 1ns;
	timeprecision 1ps;
	import dqomf_pkg::*;

	logic [31:0] ring_nums [DEPTH];
	int unsigned rd_ptr;
	int unsigned wr_ptr;
	int unsigned occ;
	logic [31:0] next_num;
	logic        uopc_en;
	rsp_t        pending_rsp [$];
	rsp_t        want;

	function automatic rsp_t apply_request(input req_t r);
		rsp_t        res;
		logic [1:0]  sel;
		int unsigned grp;
		int unsigned prev_slot;
		int unsigned flushed;
		res = '0;
		sel = SRC_NONE;
		grp = 0;
		flushed = 0;
		case (r.req_type)
			REQ_OFFER: begin
				if (uopc_en) begin
					if (r.dec_count != 0 && r.dec_first_num == next_num) begin
						sel = SRC_DEC;
						grp = r.dec_count;
					end else if (r.uopc_count != 0 && r.uopc_first_num == next_num) begin
						sel = SRC_UOPC;
						grp = r.uopc_count;
					end
				end else if (r.dec_count != 0) begin
					if (r.dec_first_num == next_num) begin
						sel = SRC_DEC;
						grp = r.dec_count;
					end else begin
						res.status = 1'b1;
					end
				end
				// A group is taken whole or not at all.
				if (sel != SRC_NONE && grp <= GROUP_MAX && grp <= DEPTH - occ) begin
					repeat (grp) begin
						ring_nums[PTR_W'(wr_ptr)] = next_num;
						wr_ptr = (wr_ptr + 1) % DEPTH;
						occ++;
						next_num++;
					end
					res.taken_source = sel;
					res.taken_count = 4'(grp);
				end
			end
			REQ_DEQUEUE, REQ_PEEK: begin
				if (occ > 0) begin
					res.head_valid = 1'b1;
					res.head_num = ring_nums[PTR_W'(rd_ptr)];
					if (r.req_type == REQ_DEQUEUE) begin
						rd_ptr = (rd_ptr + 1) % DEPTH;
						occ--;
					end
				end
			end
			default: begin
				// Walk back from the tail until the first op that survives.
				while (occ > 0) begin
					prev_slot = (wr_ptr + DEPTH - 1) % DEPTH;
					if (ring_nums[PTR_W'(prev_slot)] <= r.recovery_num)
						break;
					wr_ptr = prev_slot;
					occ--;
					flushed++;
				end
				if (next_num > r.recovery_num)
					next_num = r.recovery_num + 32'd1;
				res.flushed_count = 7'(flushed);
			end
		endcase
		res.fill_level = 7'(occ);
		return res;
	endfunction

	function automatic void cmp_field(input string fname, input logic [31:0] exp_val,
			input logic [31:0] act_val);
		if (act_val !== exp_val) begin
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
				$realtime, fname, exp_val, act_val);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr = 0;
			wr_ptr = 0;
			occ = 0;
			next_num = 32'd1;
			uopc_en = 1'b0;
			pending_rsp.delete();
			fail_count = 0;
		end else begin
			if (cfg_we)
				uopc_en = cfg_wdata;
			if (req_mon.valid && req_mon.ready)
				pending_rsp.push_back(apply_request(req_mon.data));
			if (rsp_mon.valid && rsp_mon.ready) begin
				if (pending_rsp.size() == 0) begin
					$display("%0t: response transaction with no request outstanding, actual 0x%0h",
						$realtime, rsp_mon.data);
					fail_count++;
				end else begin
					want = pending_rsp.pop_front();
					cmp_field("taken_source", 32'(want.taken_source),
						32'(rsp_mon.data.taken_source));
					cmp_field("taken_count", 32'(want.taken_count),
						32'(rsp_mon.data.taken_count));
					cmp_field("head_valid", 32'(want.head_valid), 32'(rsp_mon.data.head_valid));
					cmp_field("head_num", want.head_num, rsp_mon.data.head_num);
					cmp_field("flushed_count", 32'(want.flushed_count),
						32'(rsp_mon.data.flushed_count));
					cmp_field("fill_level", 32'(want.fill_level), 32'(rsp_mon.data.fill_level));
					cmp_field("status", 32'(want.status), 32'(rsp_mon.data.status));
				end
			end
		end
		waiting = pending_rsp.size();
		model_next_num = next_num;
		model_fill = 7'(occ);
	end

endmodule

// ===== tb/sv/decode_queue_ordered_merge_flush_top_test.sv =====
// Top of the decode queue testbench: clock, reset, request and response drivers,
// register writes and the verdict. Depends on dqomf_pkg, dqomf_if.sv, the block's
// top level and decode_queue_checker.
module decode_queue_ordered_merge_flush_top_test;
	timeunit 1ns;
	timeprecision 1ps;
	import dqomf_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int LONG_HOLD   = 300;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_wdata;
	int          fail_count;
	int          waiting;
	logic [31:0] model_next_num;
	logic [6:0]  model_fill;
	int          cycle_count = 0;
	bit          long_hold = 0;
	bit          rsp_idle = 1;
	bit          req_idle = 1;
	int          n_offer = 0;
	int          n_dequeue = 0;
	int          n_peek = 0;
	int          n_recover = 0;

	dqomf_req_if req_ch ();
	dqomf_rsp_if rsp_ch ();

	decode_queue_ordered_merge_flush_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.req      (req_ch),
		.rsp      (rsp_ch)
	);

	decode_queue_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.req_mon       (req_ch),
		.rsp_mon       (rsp_ch),
		.fail_count    (fail_count),
		.waiting       (waiting),
		.model_next_num(model_next_num),
		.model_fill    (model_fill)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d responses outstanding",
				cycle_count, waiting);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Response side: random stall bursts, plus one long hold-off on request.
	initial begin
		int   stall_left;
		logic rdy;
		stall_left = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				rdy = 1'b0;
			end else if (long_hold) begin
				long_hold = 0;
				stall_left = LONG_HOLD - 1;
				rdy = 1'b0;
			end else if (rsp_idle && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(0, 15);
				rdy = 1'b0;
			end else begin
				rdy = 1'b1;
			end
			rsp_ch.ready <= rdy;
		end
	end

	// Called at a falling edge; returns at the falling edge after the transaction.
	task automatic issue(input req_t r);
		req_ch.data <= r;
		req_ch.valid <= 1'b1;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		case (r.req_type)
			REQ_OFFER:   n_offer++;
			REQ_DEQUEUE: n_dequeue++;
			REQ_PEEK:    n_peek++;
			default:     n_recover++;
		endcase
		@(negedge clk);
	endtask

	task automatic issue_fields(input logic [1:0] kind, input logic [3:0] dcnt,
			input logic [31:0] dfirst, input logic [3:0] ucnt, input logic [31:0] ufirst,
			input logic [31:0] rnum);
		req_t r;
		r.req_type = kind;
		r.dec_count = dcnt;
		r.dec_first_num = dfirst;
		r.uopc_count = ucnt;
		r.uopc_first_num = ufirst;
		r.recovery_num = rnum;
		issue(r);
	endtask

	// The register is only written once every response has come back.
	task automatic write_uopc_enable(input logic value);
		req_ch.valid <= 1'b0;
		while (waiting != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		cfg_wdata <= value;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Mostly in-sequence groups with random content, some noise and broken offers.
	function automatic req_t next_random_req();
		req_t        r;
		int          pick;
		int          offer_w;
		int unsigned grp;
		logic [31:0] nx;
		nx = model_next_num;
		r.req_type = 2'($urandom);
		r.dec_count = 4'($urandom);
		r.dec_first_num = $urandom;
		r.uopc_count = 4'($urandom);
		r.uopc_first_num = $urandom;
		r.recovery_num = $urandom;
		pick = $urandom_range(0, 99);
		offer_w = (model_fill > 7'(DEPTH - 8)) ? 30 : 55;
		if (pick < 8)
			return r;
		if (pick < 13) begin
			r.req_type = REQ_RECOVER;
			case ($urandom_range(0, 9))
				0: r.recovery_num = nx + 32'($urandom_range(0, 4));
				1: ;
				default: r.recovery_num = nx - 32'($urandom_range(1, model_fill + 2));
			endcase
			return r;
		end
		if (pick < 21) begin
			r.req_type = REQ_PEEK;
			return r;
		end
		if (pick >= 21 + offer_w) begin
			r.req_type = REQ_DEQUEUE;
			return r;
		end
		r.req_type = REQ_OFFER;
		grp = ($urandom_range(0, 19) == 0) ? $urandom_range(GROUP_MAX + 1, 15)
			: $urandom_range(1, GROUP_MAX);
		case ($urandom_range(0, 5))
			0, 1: begin
				r.dec_count = 4'(grp);
				r.dec_first_num = nx;
			end
			2: begin
				r.uopc_count = 4'(grp);
				r.uopc_first_num = nx;
				r.dec_first_num = nx + 32'($urandom_range(1, 3));
			end
			3: begin
				r.dec_count = 4'(grp);
				r.dec_first_num = nx;
				r.uopc_first_num = nx;
			end
			4: begin
				r.dec_count = 4'd0;
				r.dec_first_num = nx;
				r.uopc_count = 4'(grp);
				r.uopc_first_num = nx;
			end
			default: begin
				r.dec_first_num = nx - 32'd1;
				r.uopc_first_num = nx + 32'd1;
			end
		endcase
		return r;
	endfunction

	task automatic run_random(input int count, input int hold_at);
		for (int i = 0; i < count; i++) begin
			if (i == hold_at)
				long_hold = 1;
			issue(next_random_req());
			if (req_idle && $urandom_range(0, 5) == 0) begin
				req_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 16)) @(negedge clk);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Decode-only mode: empty queue, ignored and refused groups, a taken group, then a flush.
		write_uopc_enable(1'b0);
		issue_fields(REQ_PEEK, 4'd0, 32'd0, 4'd0, 32'd0, 32'd0);
		issue_fields(REQ_DEQUEUE, 4'd0, 32'd0, 4'd0, 32'd0, 32'd0);
		issue_fields(REQ_RECOVER, 4'd0, 32'd0, 4'd0, 32'd0, 32'd0);
		issue_fields(REQ_OFFER, 4'd0, 32'd0, 4'd3, 32'd1, 32'd0);
		issue_fields(REQ_OFFER, 4'd4, 32'hFFFF_FFFF, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		issue_fields(REQ_OFFER, 4'd15, 32'd1, 4'd0, 32'd0, 32'd0);
		issue_fields(REQ_OFFER, 4'd9, 32'd1, 4'd0, 32'd0, 32'd0);
		issue_fields(REQ_OFFER, 4'd8, 32'd1, 4'd0, 32'd0, 32'd0);
		issue_fields(REQ_PEEK, 4'd0, 32'd0, 4'd0, 32'd0, 32'd0);
		issue_fields(REQ_DEQUEUE, 4'd0, 32'd0, 4'd0, 32'd0, 32'd0);
		issue_fields(REQ_RECOVER, 4'd0, 32'd0, 4'd0, 32'd0, 32'd5);
		issue_fields(REQ_RECOVER, 4'd0, 32'd0, 4'd0, 32'd0, 32'hFFFF_FFFF);

		// Both sources enabled: source priority, zero-count and oversized groups, a full queue.
		write_uopc_enable(1'b1);
		issue_fields(REQ_OFFER, 4'd0, model_next_num, 4'd2, model_next_num, 32'd0);
		issue_fields(REQ_OFFER, 4'd3, model_next_num, 4'd5, model_next_num, 32'd0);
		issue_fields(REQ_OFFER, 4'd3, 32'd0, 4'd8, model_next_num, 32'd0);
		issue_fields(REQ_OFFER, 4'd2, 32'd0, 4'd2, 32'd0, 32'd0);
		issue_fields(REQ_OFFER, 4'd1, 32'd5, 4'd12, model_next_num, 32'd0);
		while (model_fill <= 7'(DEPTH - GROUP_MAX))
			issue_fields(REQ_OFFER, 4'd0, 32'd0, 4'd8, model_next_num, 32'd0);
		issue_fields(REQ_OFFER, 4'(DEPTH - model_fill), model_next_num, 4'd0, 32'd0, 32'd0);
		issue_fields(REQ_OFFER, 4'd1, model_next_num, 4'd1, model_next_num, 32'd0);
		issue_fields(REQ_RECOVER, 4'd0, 32'd0, 4'd0, 32'd0, 32'd0);
		issue_fields(REQ_PEEK, 4'd0, 32'd0, 4'd0, 32'd0, 32'd0);

		run_random(600, 200);
		write_uopc_enable(1'b0);
		run_random(400, -1);
		write_uopc_enable(1'b1);
		req_idle = 0;
		rsp_idle = 0;
		run_random(400, -1);

		req_ch.valid <= 1'b0;
		while (waiting != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		$display("Run covered %0d offers, %0d dequeues, %0d peeks and %0d recovers,",
			n_offer, n_dequeue, n_peek, n_recover);
		$display("in decode-only and merged modes, with a full queue and a long output stall.");
		if (fail_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
